/* design/bgd_pkg.sv */
// shared types and constants for the button gesture detector
package bgd_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned DEB_W       = 10;
  localparam int unsigned SEC_W       = 6;
  localparam int unsigned MS_W        = 10;

  localparam logic [DEB_W-1:0]   STABLE_MAX  = 10'd1023;
  localparam logic [SEC_W-1:0]   SEC_MAX     = 6'd63;
  localparam logic [MS_W-1:0]    MS_LAST     = 10'd999;

  localparam logic [DEB_W-1:0]   RST_DEBOUNCE     = 10'd30;
  localparam logic [LIMIT_W-1:0] RST_FIRST_LIMIT  = 16'd800;
  localparam logic [LIMIT_W-1:0] RST_SECOND_WIN   = 16'd1500;
  localparam logic [LIMIT_W-1:0] RST_LONG_PRESS   = 16'd3000;
  localparam logic [SEC_W-1:0]   RST_CONFIRM_SECS = 6'd5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AP_MODE      = 3'd0,
    REG_DEBOUNCE     = 3'd1,
    REG_FIRST_LIMIT  = 3'd2,
    REG_SECOND_WIN   = 3'd3,
    REG_LONG_PRESS   = 3'd4,
    REG_CONFIRM_SECS = 3'd5
  } reg_index_e;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_ENTER       = 3'd1,
    EV_CONFIRMED   = 3'd2,
    EV_TIMEOUT     = 3'd3,
    EV_LONG_CANCEL = 3'd4,
    EV_EXIT        = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  typedef struct packed {
    logic                ap_mode;
    logic [DEB_W-1:0]    debounce_ticks;
    logic [LIMIT_W-1:0]  first_press_limit;
    logic [LIMIT_W-1:0]  second_press_window;
    logic [LIMIT_W-1:0]  long_press_ticks;
    logic [SEC_W-1:0]    confirm_seconds;
  } cfg_t;

  typedef struct packed {
    logic             debounced_pressed;
    logic             confirm_active;
    logic [SEC_W-1:0] seconds_left;
    event_e           event_res;
  } res_t;

endpackage

/* design/bgd_core.sv */
// gesture state registers and the per-tick update logic
module bgd_core #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          raw_i,
  input  bgd_pkg::cfg_t cfg_i,
  output bgd_pkg::res_t res_o
);

  localparam int unsigned CW = (TIMER_WIDTH > bgd_pkg::LIMIT_W) ? TIMER_WIDTH
                                                                : bgd_pkg::LIMIT_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

  logic                         last_raw_q, last_raw_d;
  logic [bgd_pkg::DEB_W-1:0]    stable_q, stable_d;
  bgd_pkg::phase_e              phase_q, phase_d;
  logic [TIMER_WIDTH-1:0]       gtimer_q, gtimer_d;
  logic                         confirm_q, confirm_d;
  logic [bgd_pkg::MS_W-1:0]     ms_q, ms_d;
  logic [bgd_pkg::SEC_W-1:0]    secs_q, secs_d;
  logic [TIMER_WIDTH-1:0]       hold_q, hold_d;
  logic                         armed_q, armed_d;
  logic                         seen_q, seen_d;
  logic                         fired_q, fired_d;

  logic                         pressed;
  logic                         timed_out;
  logic                         long_hold;
  logic [TIMER_WIDTH-1:0]       gtimer_inc;
  bgd_pkg::event_e              ev;

  always_comb begin
    last_raw_d = raw_i;
    stable_d   = (raw_i != last_raw_q) ? '0 :
                 ((stable_q == bgd_pkg::STABLE_MAX) ? stable_q : stable_q + 1'b1);
    pressed    = raw_i && (stable_d > cfg_i.debounce_ticks);

    // raw hold tracking
    hold_d  = raw_i ? ((hold_q == TIMER_MAX) ? hold_q : hold_q + 1'b1) : '0;
    fired_d = raw_i ? fired_q : 1'b0;
    long_hold = raw_i && (CW'(hold_d) > CW'(cfg_i.long_press_ticks));

    gtimer_inc = (gtimer_q == TIMER_MAX) ? gtimer_q : gtimer_q + 1'b1;

    phase_d   = phase_q;
    gtimer_d  = gtimer_q;
    confirm_d = confirm_q;
    ms_d      = ms_q;
    secs_d    = secs_q;
    armed_d   = armed_q;
    seen_d    = seen_q;
    timed_out = 1'b0;
    ev        = bgd_pkg::EV_NONE;

    if (cfg_i.ap_mode) begin
      phase_d   = bgd_pkg::PH_IDLE;
      gtimer_d  = '0;
      confirm_d = 1'b0;
      ms_d      = '0;
      secs_d    = '0;
      armed_d   = 1'b0;
      seen_d    = 1'b0;
      if (long_hold && !fired_d) begin
        fired_d = 1'b1;
        ev      = bgd_pkg::EV_EXIT;
      end
    end else if (confirm_q) begin
      if (ms_q == bgd_pkg::MS_LAST) begin
        ms_d   = '0;
        secs_d = (secs_q == bgd_pkg::SEC_MAX) ? secs_q : secs_q + 1'b1;
      end else begin
        ms_d   = ms_q + 1'b1;
      end
      timed_out = (secs_d > cfg_i.confirm_seconds) ||
                  ((secs_d == cfg_i.confirm_seconds) && (ms_d != '0));
      if (timed_out || long_hold || (armed_q && seen_q && !raw_i)) begin
        confirm_d = 1'b0;
        ms_d      = '0;
        secs_d    = '0;
        armed_d   = 1'b0;
        seen_d    = 1'b0;
        ev        = timed_out ? bgd_pkg::EV_TIMEOUT :
                    (long_hold ? bgd_pkg::EV_LONG_CANCEL : bgd_pkg::EV_CONFIRMED);
      end else if (!armed_q) begin
        if (!raw_i) begin
          armed_d = 1'b1;
        end
      end else if (pressed) begin
        seen_d = 1'b1;
      end
    end else begin
      unique case (phase_q)
        bgd_pkg::PH_IDLE: begin
          if (pressed) begin
            phase_d  = bgd_pkg::PH_FIRST;
            gtimer_d = '0;
          end
        end
        bgd_pkg::PH_FIRST: begin
          gtimer_d = gtimer_inc;
          if (!pressed) begin
            phase_d  = bgd_pkg::PH_SECOND;
            gtimer_d = '0;
          end else if (CW'(gtimer_inc) > CW'(cfg_i.first_press_limit)) begin
            phase_d = bgd_pkg::PH_IDLE;
          end
        end
        bgd_pkg::PH_SECOND: begin
          gtimer_d = gtimer_inc;
          if (pressed) begin
            phase_d   = bgd_pkg::PH_IDLE;
            confirm_d = 1'b1;
            ms_d      = '0;
            secs_d    = '0;
            armed_d   = 1'b0;
            seen_d    = 1'b0;
            ev        = bgd_pkg::EV_ENTER;
          end else if (CW'(gtimer_inc) > CW'(cfg_i.second_press_window)) begin
            phase_d = bgd_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = bgd_pkg::PH_IDLE;
        end
      endcase
    end

    res_o.debounced_pressed = pressed;
    res_o.confirm_active    = confirm_d;
    res_o.seconds_left      = (confirm_d && (secs_d < cfg_i.confirm_seconds)) ?
                              cfg_i.confirm_seconds - secs_d : '0;
    res_o.event_res         = ev;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= '0;
      phase_q    <= bgd_pkg::PH_IDLE;
      gtimer_q   <= '0;
      confirm_q  <= 1'b0;
      ms_q       <= '0;
      secs_q     <= '0;
      hold_q     <= '0;
      armed_q    <= 1'b0;
      seen_q     <= 1'b0;
      fired_q    <= 1'b0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      phase_q    <= phase_d;
      gtimer_q   <= gtimer_d;
      confirm_q  <= confirm_d;
      ms_q       <= ms_d;
      secs_q     <= secs_d;
      hold_q     <= hold_d;
      armed_q    <= armed_d;
      seen_q     <= seen_d;
      fired_q    <= fired_d;
    end
  end

endmodule

/* design/button_gesture_detector_top.sv */
// button gesture detector top level: handshakes, config registers, result register
// result path: an accepted input item passes the input register, then the result register
// throughput: one tick item per cycle unless stalled; the state update fits between the two registers
// the input stage only stalls while a held result is stalled downstream
// reset: async active low; gesture state cleared, config registers to their defaults
module button_gesture_detector_top #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            button_raw_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            debounced_pressed_o,
  output logic                            confirm_active_o,
  output logic [bgd_pkg::SEC_W-1:0]       seconds_left_o,
  output logic [2:0]                      event_res_o,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // config registers
  bgd_pkg::cfg_t cfg_q;

  // input stage: one raw sample waiting for its update
  logic          in_valid_q, in_valid_d;
  logic          raw_q;

  // result register
  logic          out_valid_q, out_valid_d;
  bgd_pkg::res_t res_q;
  bgd_pkg::res_t res_c;

  logic          in_acc;
  logic          advance;

  // the item moves on when the result register is empty or being emptied
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_acc | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      raw_q <= button_raw_i;
    end
    if (advance) begin
      res_q <= res_c;
    end
  end

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ap_mode             <= 1'b0;
      cfg_q.debounce_ticks      <= bgd_pkg::RST_DEBOUNCE;
      cfg_q.first_press_limit   <= bgd_pkg::RST_FIRST_LIMIT;
      cfg_q.second_press_window <= bgd_pkg::RST_SECOND_WIN;
      cfg_q.long_press_ticks    <= bgd_pkg::RST_LONG_PRESS;
      cfg_q.confirm_seconds     <= bgd_pkg::RST_CONFIRM_SECS;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bgd_pkg::REG_AP_MODE:      cfg_q.ap_mode             <= cfg_data_i[0];
        bgd_pkg::REG_DEBOUNCE:     cfg_q.debounce_ticks      <= cfg_data_i[bgd_pkg::DEB_W-1:0];
        bgd_pkg::REG_FIRST_LIMIT:  cfg_q.first_press_limit   <= cfg_data_i;
        bgd_pkg::REG_SECOND_WIN:   cfg_q.second_press_window <= cfg_data_i;
        bgd_pkg::REG_LONG_PRESS:   cfg_q.long_press_ticks    <= cfg_data_i;
        bgd_pkg::REG_CONFIRM_SECS: cfg_q.confirm_seconds     <= cfg_data_i[bgd_pkg::SEC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per-tick debounce, gesture and confirm logic
  bgd_core #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .raw_i (raw_q),
    .cfg_i (cfg_q),
    .res_o (res_c)
  );

  assign out_valid_o         = out_valid_q;
  assign debounced_pressed_o = res_q.debounced_pressed;
  assign confirm_active_o    = res_q.confirm_active;
  assign seconds_left_o      = res_q.seconds_left;
  assign event_res_o         = res_q.event_res;

endmodule

/* design/bgd_checker.sv */
// port-level checks for the button gesture detector and their bind
module bgd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      debounced_pressed_o,
  input logic                      confirm_active_o,
  input logic [bgd_pkg::SEC_W-1:0] seconds_left_o,
  input logic [2:0]                event_res_o
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o) &&
    $stable(seconds_left_o) && $stable(confirm_active_o) && $stable(debounced_pressed_o))
    else $error("stalled result changed");

  // input only backs up behind a stalled result
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // seconds only count while confirm is open
  a_secs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (seconds_left_o != '0) |-> confirm_active_o)
    else $error("seconds left outside confirm");

  // entering opens confirm, every closing event leaves it closed
  a_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ((event_res_o == bgd_pkg::EV_ENTER) && confirm_active_o) ||
      (((event_res_o == bgd_pkg::EV_CONFIRMED) || (event_res_o == bgd_pkg::EV_TIMEOUT) ||
        (event_res_o == bgd_pkg::EV_LONG_CANCEL) || (event_res_o == bgd_pkg::EV_EXIT)) &&
       !confirm_active_o) ||
      (event_res_o == bgd_pkg::EV_NONE))
    else $error("event and confirm state disagree");

endmodule

bind button_gesture_detector_top bgd_checker u_bgd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_stall_o         (in_stall_o),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .debounced_pressed_o(debounced_pressed_o),
  .confirm_active_o   (confirm_active_o),
  .seconds_left_o     (seconds_left_o),
  .event_res_o        (event_res_o)
);

/* test/button_gesture_detector_top_test.sv */
// self-checking testbench for the button gesture detector top level
module button_gesture_detector_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMER_W       = 16;
  localparam int unsigned RANDOM_TICKS  = 500;
  localparam int unsigned SETTLE_CYCLES = 4;   // two register stages plus margin
  localparam int unsigned TAIL_CYCLES   = 8;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RUN_LIMIT_NS  = 20_000_000;
  localparam int unsigned CFG_DW        = bgd_pkg::CFG_DATA_W;

  // indexes past the last register, writes there must be dropped
  localparam logic [bgd_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [bgd_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  // ---------------------------------------------------------------------------
  // clock, reset and block signals
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_valid   = 1'b0;
  logic                            in_stall;
  logic                            button_raw = 1'b0;
  logic                            out_valid;
  logic                            out_stall  = 1'b0;
  logic                            debounced_pressed;
  logic                            confirm_active;
  logic [bgd_pkg::SEC_W-1:0]       seconds_left;
  logic [2:0]                      event_res;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [bgd_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [bgd_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  button_gesture_detector_top #(
    .TIMER_WIDTH(TIMER_W)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .button_raw_i        (button_raw),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .debounced_pressed_o (debounced_pressed),
    .confirm_active_o    (confirm_active),
    .seconds_left_o      (seconds_left),
    .event_res_o         (event_res),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // shared bookkeeping
  // ---------------------------------------------------------------------------
  logic          raw_levels[$];      // button levels waiting to be sent, one per tick item
  bgd_pkg::res_t tick_outcomes[$];   // predicted outcome of every accepted tick, oldest first
  int unsigned   ticks_queued = 0;
  int unsigned   mismatches   = 0;
  logic          steady       = 1'b0; // no sender gaps and no receiver stalls while set

  // ---------------------------------------------------------------------------
  // gesture predictor: own copy of the registers and of the detector state
  // ---------------------------------------------------------------------------
  bgd_pkg::cfg_t             det_cfg;
  logic                      det_last_raw;
  logic [bgd_pkg::DEB_W-1:0] det_stable;
  bgd_pkg::phase_e           det_phase;
  logic [TIMER_W-1:0]        det_timer;
  logic                      det_confirm;
  logic [bgd_pkg::MS_W-1:0]  det_ms;
  logic [bgd_pkg::SEC_W-1:0] det_secs;
  logic [TIMER_W-1:0]        det_hold;
  logic                      det_armed;
  logic                      det_press_seen;
  logic                      det_hold_fired;

  function automatic void close_confirm();
    det_confirm    = 1'b0;
    det_ms         = '0;
    det_secs       = '0;
    det_armed      = 1'b0;
    det_press_seen = 1'b0;
  endfunction

  function automatic void clear_detector();
    det_cfg.ap_mode             = 1'b0;
    det_cfg.debounce_ticks      = bgd_pkg::RST_DEBOUNCE;
    det_cfg.first_press_limit   = bgd_pkg::RST_FIRST_LIMIT;
    det_cfg.second_press_window = bgd_pkg::RST_SECOND_WIN;
    det_cfg.long_press_ticks    = bgd_pkg::RST_LONG_PRESS;
    det_cfg.confirm_seconds     = bgd_pkg::RST_CONFIRM_SECS;
    det_last_raw   = 1'b0;
    det_stable     = '0;
    det_phase      = bgd_pkg::PH_IDLE;
    det_timer      = '0;
    det_hold       = '0;
    det_hold_fired = 1'b0;
    close_confirm();
  endfunction

  // advance the detector by one tick and return what the block must report
  function automatic bgd_pkg::res_t detect_tick(input logic raw);
    bgd_pkg::res_t r;
    logic pressed;
    logic timed_out;
    r = '0;
    r.event_res = bgd_pkg::EV_NONE;

    // debounce: count ticks since the raw level last changed
    if (raw != det_last_raw) begin
      det_last_raw = raw;
      det_stable   = '0;
    end else if (det_stable != bgd_pkg::STABLE_MAX) begin
      det_stable = det_stable + 1'b1;
    end
    pressed = raw && (det_stable > det_cfg.debounce_ticks);

    // raw hold length, release clears the exit latch
    if (raw) begin
      if (det_hold != '1) det_hold = det_hold + 1'b1;
    end else begin
      det_hold       = '0;
      det_hold_fired = 1'b0;
    end

    if (det_cfg.ap_mode) begin
      det_phase = bgd_pkg::PH_IDLE;
      det_timer = '0;
      close_confirm();
      if (raw && !det_hold_fired && det_hold > det_cfg.long_press_ticks) begin
        det_hold_fired = 1'b1;
        r.event_res    = bgd_pkg::EV_EXIT;
      end
    end else if (det_confirm) begin
      det_ms = det_ms + 1'b1;
      if (det_ms > bgd_pkg::MS_LAST) begin
        det_ms = '0;
        if (det_secs != bgd_pkg::SEC_MAX) det_secs = det_secs + 1'b1;
      end
      timed_out = (det_secs > det_cfg.confirm_seconds) ||
                  (det_secs == det_cfg.confirm_seconds && det_ms != '0);
      if (timed_out) begin
        close_confirm();
        r.event_res = bgd_pkg::EV_TIMEOUT;
      end else if (raw && det_hold > det_cfg.long_press_ticks) begin
        close_confirm();
        r.event_res = bgd_pkg::EV_LONG_CANCEL;
      end else if (!det_armed) begin
        if (!raw) det_armed = 1'b1;
      end else if (det_press_seen && !raw) begin
        close_confirm();
        r.event_res = bgd_pkg::EV_CONFIRMED;
      end else if (pressed) begin
        det_press_seen = 1'b1;
      end
    end else begin
      case (det_phase)
        bgd_pkg::PH_IDLE: begin
          if (pressed) begin
            det_phase = bgd_pkg::PH_FIRST;
            det_timer = '0;
          end
        end
        bgd_pkg::PH_FIRST: begin
          if (det_timer != '1) det_timer = det_timer + 1'b1;
          if (!pressed) begin
            det_phase = bgd_pkg::PH_SECOND;
            det_timer = '0;
          end else if (det_timer > det_cfg.first_press_limit) begin
            det_phase = bgd_pkg::PH_IDLE;
          end
        end
        bgd_pkg::PH_SECOND: begin
          if (det_timer != '1) det_timer = det_timer + 1'b1;
          if (pressed) begin
            det_phase = bgd_pkg::PH_IDLE;
            close_confirm();
            det_confirm = 1'b1;
            r.event_res = bgd_pkg::EV_ENTER;
          end else if (det_timer > det_cfg.second_press_window) begin
            det_phase = bgd_pkg::PH_IDLE;
          end
        end
        default: det_phase = bgd_pkg::PH_IDLE;
      endcase
    end

    if (det_confirm && det_secs < det_cfg.confirm_seconds)
      r.seconds_left = det_cfg.confirm_seconds - det_secs;
    r.debounced_pressed = pressed;
    r.confirm_active    = det_confirm;
    return r;
  endfunction

  function automatic void note_error(input string what, input int unsigned want,
                                     input int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // tick driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      button_raw <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      // an item taken at this edge advances the predictor
      if (in_valid && !in_stall)
        tick_outcomes.push_back(detect_tick(button_raw));
      // a stalled item stays put, otherwise present the next one or idle
      if (!in_valid || !in_stall) begin
        if (gap_left != 0 && !steady) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (raw_levels.size() != 0) begin
          in_valid   <= 1'b1;
          button_raw <= raw_levels.pop_front();
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compare field by field, stall on a rotating pattern
  // ---------------------------------------------------------------------------
  logic [15:0]   stall_pattern;
  logic [5:0]    pattern_age;
  bgd_pkg::res_t oldest;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall     <= 1'b0;
      stall_pattern <= '0;
      pattern_age   <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (tick_outcomes.size() == 0) begin
          note_error("result with no tick pending", 0, 1);
        end else begin
          oldest = tick_outcomes.pop_front();
          if (debounced_pressed !== oldest.debounced_pressed)
            note_error("debounced_pressed", oldest.debounced_pressed, debounced_pressed);
          if (confirm_active !== oldest.confirm_active)
            note_error("confirm_active", oldest.confirm_active, confirm_active);
          if (seconds_left !== oldest.seconds_left)
            note_error("seconds_left", oldest.seconds_left, seconds_left);
          if (event_res !== oldest.event_res)
            note_error("event_res", oldest.event_res, event_res);
        end
      end
      out_stall   <= steady ? 1'b0 : stall_pattern[0];
      pattern_age <= pattern_age + 1'b1;
      // each time the age counter wraps, pick a fresh pattern: none, sparse, dense or long runs
      if (pattern_age == '0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= '0;
          1:       stall_pattern <= 16'($urandom & $urandom);
          2:       stall_pattern <= 16'($urandom);
          default: stall_pattern <= 16'h0FF0;
        endcase
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic hold_level(input logic lvl, input int unsigned n);
    repeat (n) raw_levels.push_back(lvl);
    ticks_queued += n;
  endtask

  // press, release, press again: the shape that opens confirm mode
  task automatic double_press(input int unsigned p1, input int unsigned gap,
                              input int unsigned p2);
    hold_level(1'b1, p1);
    hold_level(1'b0, gap);
    hold_level(1'b1, p2);
  endtask

  task automatic scatter(input int unsigned n);
    repeat (n) hold_level(logic'($urandom_range(0, 1)), 1);
  endtask

  // sampled on the falling edge so the queues and valid are settled
  task automatic wait_idle();
    do @(negedge clk);
    while (raw_levels.size() != 0 || in_valid || tick_outcomes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bgd_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bgd_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      bgd_pkg::REG_AP_MODE:      det_cfg.ap_mode             = data[0];
      bgd_pkg::REG_DEBOUNCE:     det_cfg.debounce_ticks      = data[bgd_pkg::DEB_W-1:0];
      bgd_pkg::REG_FIRST_LIMIT:  det_cfg.first_press_limit   = data[bgd_pkg::LIMIT_W-1:0];
      bgd_pkg::REG_SECOND_WIN:   det_cfg.second_press_window = data[bgd_pkg::LIMIT_W-1:0];
      bgd_pkg::REG_LONG_PRESS:   det_cfg.long_press_ticks    = data[bgd_pkg::LIMIT_W-1:0];
      bgd_pkg::REG_CONFIRM_SECS: det_cfg.confirm_seconds     = data[bgd_pkg::SEC_W-1:0];
      default: ;
    endcase
  endtask

  // narrow registers sometimes get junk above their width, which must be dropped
  task automatic apply_settings(input int unsigned ap, input int unsigned deb,
                                input int unsigned first, input int unsigned second,
                                input int unsigned long_hold, input int unsigned secs);
    logic dirty;
    dirty = logic'($urandom_range(0, 1));
    wait_idle();
    write_reg(bgd_pkg::REG_AP_MODE,
              CFG_DW'(ap) | (dirty ? (CFG_DW'($urandom) & ~16'h1) : '0));
    write_reg(bgd_pkg::REG_DEBOUNCE,
              CFG_DW'(deb) | (dirty ? (CFG_DW'($urandom) & ~16'h3FF) : '0));
    write_reg(bgd_pkg::REG_FIRST_LIMIT,  CFG_DW'(first));
    write_reg(bgd_pkg::REG_SECOND_WIN,   CFG_DW'(second));
    write_reg(bgd_pkg::REG_LONG_PRESS,   CFG_DW'(long_hold));
    write_reg(bgd_pkg::REG_CONFIRM_SECS,
              CFG_DW'(secs) | (dirty ? (CFG_DW'($urandom) & ~16'h3F) : '0));
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ap;
    int unsigned deb;
    int unsigned first;
    int unsigned second;
    int unsigned long_hold;
    int unsigned secs;
    int unsigned start;
    int unsigned kind;

    clear_detector();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    // defaults after reset: a short press never clears the 30 tick debounce
    hold_level(1'b1, 3);
    hold_level(1'b0, 2);

    // zero debounce, tight windows, zero confirm length: enter then time out at once
    apply_settings(0, 0, 2, 2, 5, 0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    double_press(3, 1, 2);
    hold_level(1'b0, 2);

    // confirm path: release to arm, fresh press, counted on its release
    apply_settings(0, 0, 2, 2, 5, 3);
    double_press(3, 1, 2);
    hold_level(1'b0, 1);
    hold_level(1'b1, 2);
    hold_level(1'b0, 1);

    // long hold right after entry cancels
    double_press(3, 1, 8);
    hold_level(1'b0, 1);

    // access-point mode: one exit per hold, a release re-arms it
    apply_settings(1, 0, 2, 2, 5, 3);
    hold_level(1'b1, 9);
    hold_level(1'b0, 1);
    hold_level(1'b1, 7);
    hold_level(1'b0, 1);

    // --- random part: small settings so gestures complete in a few ticks ---
    start = ticks_queued;
    while (ticks_queued - start < RANDOM_TICKS) begin
      ap        = ($urandom_range(0, 4) == 0) ? 1 : 0;
      deb       = $urandom_range(0, 3);
      first     = $urandom_range(0, 10);
      second    = $urandom_range(0, 12);
      long_hold = $urandom_range(0, 24);
      secs      = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 63);
      apply_settings(ap, deb, first, second, long_hold, secs);
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 9);
        if (ap != 0 && kind < 7) begin
          // holds around the long-press threshold
          hold_level(1'b1, long_hold + $urandom_range(0, 6) - ((long_hold > 2) ? 2 : 0));
          hold_level(1'b0, $urandom_range(1, 4));
        end else if (kind < 6) begin
          // well-formed double press, then something happens in confirm mode
          double_press(deb + 2 + $urandom_range(0, first), $urandom_range(1, 3),
                       deb + 2 + $urandom_range(0, 2));
          case ($urandom_range(0, 3))
            0: begin
              hold_level(1'b0, $urandom_range(1, 3));
              hold_level(1'b1, deb + 2 + $urandom_range(0, 2));
              hold_level(1'b0, $urandom_range(1, 3));
            end
            1: begin
              hold_level(1'b1, long_hold + $urandom_range(0, 3));
              hold_level(1'b0, 1);
            end
            2: hold_level(1'b0, $urandom_range(2, 8));
            default: scatter($urandom_range(3, 10));
          endcase
        end else if (kind < 8) begin
          // broken gesture: first press too long or second press too late
          if (kind == 6) begin
            hold_level(1'b1, deb + 2 + first + $urandom_range(0, 3));
            hold_level(1'b0, 2);
          end else begin
            double_press(deb + 2, second + $urandom_range(0, 3), deb + 2);
            hold_level(1'b0, 2);
          end
        end else begin
          scatter($urandom_range(3, 16));
        end
      end
    end

    // --- back to back, sent without gaps or stalls ---
    // the largest debounce never yields a press on a short hold
    apply_settings(0, 1023, 800, 1500, 3000, 5);
    steady = 1'b1;
    hold_level(1'b1, 40);
    hold_level(1'b0, 2);

    // default windows: enter confirm, arm on release, confirm on the next release
    apply_settings(0, 0, 800, 1500, 3000, 5);
    double_press(3, 1, 2);
    hold_level(1'b0, 2);
    hold_level(1'b1, 3);
    hold_level(1'b0, 2);

    // --- wind down ---
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && tick_outcomes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #(RUN_LIMIT_NS);
    $display("[%0t] run limit reached, %0d ticks still pending", $realtime,
             tick_outcomes.size() + raw_levels.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
